@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define STSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is also evaluated while the reset is high.
`define STSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/stsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsd_pkg
// Field widths, operation and status codes, and the command and status
// bundles that join the sorted table controller to its datapath.
// ----------------------------------------------------------------------------
package stsd_pkg;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ORDER     = 2'd3;

   // Address source for the table read port.
   typedef enum logic [1:0] {
      RD_ZERO,
      RD_NEXT,
      RD_NEXT2,
      RD_TAIL
   } rd_sel_type;

   // Source of the reported index.
   typedef enum logic [1:0] {
      RIDX_ZERO,
      RIDX_PTR,
      RIDX_COUNT
   } res_idx_type;

   typedef struct packed {
      logic                accept;
      logic                ptr_inc;
      rd_sel_type          rd_sel;
      logic                wr_tail;
      logic                wr_shift;
      logic                cnt_inc;
      logic                cnt_dec;
      logic                res_load;
      logic [STATUS_W-1:0] res_status;
      logic                res_hit;
      res_idx_type         res_idx;
      logic                out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic cnt_full;
      logic key_gt;
      logic key_eq;
      logic next_lt_cnt;
      logic next2_lt_cnt;
      logic out_free;
   } dp_stat_type;

endpackage

@@ hw/rtl/stsd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsd_if
// Valid/ready channels for the sorted table: one for requests, one for
// responses.
// ----------------------------------------------------------------------------
interface stsd_req_if import stsd_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic signed [KEY_W-1:0] key_value;

   modport source (output valid, output cmd, output key_value, input ready);
   modport sink   (input valid, input cmd, input key_value, output ready);
endinterface

interface stsd_rsp_if import stsd_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                hit;
   logic [INDEX_W-1:0]  hit_index;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output hit, output hit_index,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input hit, input hit_index,
                   input entry_count, output ready);
endinterface

@@ hw/rtl/stsd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsd_ctrl
// Sequencer for append, search and delete; drives the datapath by commands.
// ----------------------------------------------------------------------------
module stsd_ctrl import stsd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_ready,
   input  dp_stat_type      stat,
   output dp_cmd_type       dcmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TAIL  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       del_ff, del_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      del_in   = del_ff;
      dcmd     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dcmd.accept = 1'b1;
               del_in      = (req_cmd == CMD_DELETE);
               if (req_cmd == CMD_APPEND) begin
                  if (stat.cnt_full) begin
                     dcmd.res_load   = 1'b1;
                     dcmd.res_status = ST_FULL;
                     state_in        = S_DONE;
                  end else begin
                     dcmd.rd_sel = RD_TAIL;
                     state_in    = S_TAIL;
                  end
               end else if (req_cmd == CMD_SEARCH || req_cmd == CMD_DELETE) begin
                  if (stat.cnt_zero) begin
                     dcmd.res_load   = 1'b1;
                     dcmd.res_status = ST_NOT_FOUND;
                     state_in        = S_DONE;
                  end else begin
                     dcmd.rd_sel = RD_ZERO;
                     state_in    = S_SCAN;
                  end
               end else begin
                  dcmd.res_load   = 1'b1;
                  dcmd.res_status = ST_OK;
                  state_in        = S_DONE;
               end
            end
         end
         S_TAIL: begin
            dcmd.res_load = 1'b1;
            if (!stat.cnt_zero && !stat.key_gt && !stat.key_eq) begin
               dcmd.res_status = ST_ORDER;
            end else begin
               dcmd.wr_tail    = 1'b1;
               dcmd.cnt_inc    = 1'b1;
               dcmd.res_status = ST_OK;
               dcmd.res_idx    = RIDX_COUNT;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            dcmd.rd_sel = RD_NEXT;
            if (stat.key_gt) begin
               if (stat.next_lt_cnt) begin
                  dcmd.ptr_inc = 1'b1;
               end else begin
                  dcmd.res_load   = 1'b1;
                  dcmd.res_status = ST_NOT_FOUND;
                  state_in        = S_DONE;
               end
            end else if (stat.key_eq) begin
               dcmd.res_load   = 1'b1;
               dcmd.res_status = ST_OK;
               dcmd.res_hit    = 1'b1;
               dcmd.res_idx    = RIDX_PTR;
               if (del_ff && stat.next_lt_cnt) begin
                  state_in = S_SHIFT;
               end else begin
                  dcmd.cnt_dec = del_ff;
                  state_in     = S_DONE;
               end
            end else begin
               dcmd.res_load   = 1'b1;
               dcmd.res_status = ST_NOT_FOUND;
               state_in        = S_DONE;
            end
         end
         S_SHIFT: begin
            dcmd.wr_shift = 1'b1;
            dcmd.ptr_inc  = 1'b1;
            dcmd.rd_sel   = RD_NEXT2;
            if (!stat.next2_lt_cnt) begin
               dcmd.cnt_dec = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               dcmd.out_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         del_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         del_ff   <= del_in;
      end
   end

endmodule

@@ hw/rtl/stsd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsd_dp
// Table memory, entry count, scan pointer, key compare and result registers.
// ----------------------------------------------------------------------------
module stsd_dp import stsd_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [KEY_W-1:0] req_key_value,
   input  dp_cmd_type              dcmd,
   output dp_stat_type             stat,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic                    rsp_hit,
   output logic [INDEX_W-1:0]      rsp_hit_index,
   output logic [COUNT_W-1:0]      rsp_entry_count
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = CNT_W + 1;
   localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic [VALUE_BITS-1:0] entries_ff [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [VALUE_BITS-1:0] key_ff;
   logic [VALUE_BITS-1:0] key_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      rd_addr, wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  wr_en;
   logic [POS_W-1:0]      ptr_ext, cnt_ext, next_pos, next2_pos, tail_pos;

   logic [STATUS_W-1:0]   res_status_ff;
   logic                  res_hit_ff;
   logic [INDEX_W-1:0]    res_index_ff, res_index_in;
   logic                  out_valid_ff, out_valid_in;

   // Flipping the sign bit makes unsigned order match signed order.
   assign key_in = VALUE_BITS'($unsigned(req_key_value)) ^ SIGN_BIT;

   assign ptr_ext   = POS_W'(ptr_ff);
   assign cnt_ext   = POS_W'(count_ff);
   assign next_pos  = ptr_ext + POS_W'(1);
   assign next2_pos = ptr_ext + POS_W'(2);
   assign tail_pos  = cnt_ext - POS_W'(1);

   always_comb begin
      unique case (dcmd.rd_sel)
         RD_ZERO:  rd_addr = '0;
         RD_NEXT:  rd_addr = next_pos[IDX_W-1:0];
         RD_NEXT2: rd_addr = next2_pos[IDX_W-1:0];
         RD_TAIL:  rd_addr = tail_pos[IDX_W-1:0];
      endcase
   end

   assign wr_en   = dcmd.wr_tail | dcmd.wr_shift;
   assign wr_addr = dcmd.wr_tail ? count_ff[IDX_W-1:0] : ptr_ff;
   assign wr_data = dcmd.wr_tail ? key_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (dcmd.accept) begin
         ptr_in = '0;
      end else if (dcmd.ptr_inc) begin
         ptr_in = ptr_ff + IDX_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (dcmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (dcmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      unique case (dcmd.res_idx)
         RIDX_PTR:   res_index_in = INDEX_W'(ptr_ff);
         RIDX_COUNT: res_index_in = INDEX_W'(count_ff);
         default:    res_index_in = '0;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (dcmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (dcmd.accept) begin
         key_ff <= key_in;
      end
      if (dcmd.res_load) begin
         res_status_ff <= dcmd.res_status;
         res_hit_ff    <= dcmd.res_hit;
         res_index_ff  <= res_index_in;
      end
      if (dcmd.out_load) begin
         rsp_status      <= res_status_ff;
         rsp_hit         <= res_hit_ff;
         rsp_hit_index   <= res_index_ff;
         rsp_entry_count <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid = out_valid_ff;

   assign stat.cnt_zero     = (count_ff == '0);
   assign stat.cnt_full     = (cnt_ext == POS_W'(DEPTH));
   assign stat.key_gt       = (key_ff > rd_data_ff);
   assign stat.key_eq       = (key_ff == rd_data_ff);
   assign stat.next_lt_cnt  = (next_pos < cnt_ext);
   assign stat.next2_lt_cnt = (next2_pos < cnt_ext);
   assign stat.out_free     = !out_valid_ff || rsp_ready;

endmodule

@@ hw/rtl/sorted_table_search_delete_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_search_delete_core
// Ascending table of signed values with append, search and delete.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Fields                               Transfer when
//   req_chan  in         cmd, key_value                       valid && ready
//   rsp_chan  out        status, hit, hit_index, entry_count  valid && ready
//
// One request is in flight at a time. An empty-table miss, a full-table
// append or an unused code goes from idle straight to the done state; any
// other append first compares its key with the tail entry. A scan reads one
// position after another, and a delete that hits moves each later entry down.
// A stalled response waits in the output register and holds the next
// result back in the sequencer; reset empties the table at once.
// ----------------------------------------------------------------------------
module sorted_table_search_delete_core import stsd_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   stsd_req_if.sink   req_chan,
   stsd_rsp_if.source rsp_chan
);

   // Commands from the sequencer and status back from the datapath.
   dp_cmd_type  dcmd;
   dp_stat_type stat;

   // The sequencer owns the request handshake: a request is taken only when
   // the previous one has placed its result into the output register.
   stsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .dcmd      (dcmd)
   );

   // The datapath holds the table, the entry count and the output register
   // that drives the response channel.
   stsd_dp #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_key_value   (req_chan.key_value),
      .dcmd            (dcmd),
      .stat            (stat),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_hit         (rsp_chan.hit),
      .rsp_hit_index   (rsp_chan.hit_index),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule

@@ hw/rtl/stsd_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsd_chk
// Port-level checks of the sorted table core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stsd_chk import stsd_pkg::*; #(
   parameter int DEPTH = 64
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_hit,
   input logic [COUNT_W-1:0]  rsp_entry_count
);

   // A stalled response stays offered.
   `STSD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // Requests are taken one at a time.
   `STSD_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while busy")

   // A full-table rejection reports a full count and no hit.
   `STSD_ASSERT(a_full_count, clock, reset, rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == COUNT_W'(DEPTH) && !rsp_hit, "full status with wrong count")

   // A hit always comes with an ok status.
   `STSD_ASSERT(a_hit_ok, clock, reset, rsp_valid && rsp_hit |-> rsp_status == ST_OK, "hit with error status")

   // Reset clears any pending response.
   `STSD_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind sorted_table_search_delete_core stsd_chk #(
   .DEPTH (DEPTH)
) u_stsd_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_hit         (rsp_chan.hit),
   .rsp_entry_count (rsp_chan.entry_count)
);
